// File: rtl/cde_pkg.sv
// ----------------------------------------------------------------------------
// cde_pkg
// Types, constants and calendar tables shared by the civil date converter.
// ----------------------------------------------------------------------------
package cde_pkg;

   // month numbers
   localparam logic [3:0] MON_JAN = 4'd1;
   localparam logic [3:0] MON_FEB = 4'd2;
   localparam logic [3:0] MON_MAR = 4'd3;
   localparam logic [3:0] MON_APR = 4'd4;
   localparam logic [3:0] MON_MAY = 4'd5;
   localparam logic [3:0] MON_JUN = 4'd6;
   localparam logic [3:0] MON_JUL = 4'd7;
   localparam logic [3:0] MON_AUG = 4'd8;
   localparam logic [3:0] MON_SEP = 4'd9;
   localparam logic [3:0] MON_OCT = 4'd10;
   localparam logic [3:0] MON_NOV = 4'd11;
   localparam logic [3:0] MON_DEC = 4'd12;

   localparam logic [13:0] FULL_YEAR_FIRST = 14'd1970;
   localparam logic [13:0] FULL_YEAR_LAST  = 14'd2039;
   localparam logic [13:0] YEAR_PIVOT      = 14'd40;
   localparam logic [13:0] TWO_DIGIT_FIRST = 14'd70;
   localparam logic [13:0] TWO_DIGIT_LAST  = 14'd99;
   // 2000 - 1970
   localparam logic [13:0] CENTURY_OFFSET  = 14'd30;
   // years since 1970 that are leap years have this phase mod 4
   localparam logic [1:0]  LEAP_PHASE      = 2'd2;

   localparam logic [4:0]  MAX_HOUR        = 5'd23;
   localparam logic [5:0]  MAX_MINUTE      = 6'd59;

   localparam int unsigned DAYS_PER_YEAR   = 365;
   localparam int unsigned MONTHS_PER_YEAR = 12;
   localparam int unsigned HOURS_PER_DAY   = 24;
   localparam int unsigned MINUTES_PER_HOUR = 60;
   localparam int unsigned SECONDS_PER_MINUTE = 60;
   // 1970-01-01 was a thursday
   localparam int unsigned WEEK_OFFSET     = 3;
   // ceil(2^18 / 7), exact floor for operands below 43690
   localparam int unsigned WEEK_RECIP      = 37450;
   localparam int unsigned WEEK_SHIFT      = 18;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } cde_req_type;

   typedef struct packed {
      logic [6:0]  epoch_years;
      logic [9:0]  epoch_months;
      logic [14:0] epoch_days;
      logic [11:0] epoch_weeks;
      logic [19:0] epoch_hours;
      logic [25:0] epoch_minutes;
      logic [31:0] epoch_seconds;
      logic        bad_input;
   } cde_rsp_type;

   // after field checks
   typedef struct packed {
      logic [6:0]  years;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        leap;
      logic        bad;
   } cde_chk_type;

   // after day count
   typedef struct packed {
      logic [6:0]  years;
      logic [9:0]  months;
      logic [14:0] days;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        bad;
   } cde_day_type;

   // after hour count
   typedef struct packed {
      logic [6:0]  years;
      logic [9:0]  months;
      logic [14:0] days;
      logic [11:0] weeks;
      logic [19:0] hours;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        bad;
   } cde_hrs_type;

   // after minute count
   typedef struct packed {
      logic [6:0]  years;
      logic [9:0]  months;
      logic [14:0] days;
      logic [11:0] weeks;
      logic [19:0] hours;
      logic [25:0] minutes;
      logic [5:0]  second;
      logic        bad;
   } cde_mins_type;

   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month) inside
         MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
         MON_APR, MON_JUN, MON_SEP, MON_NOV:                            len = 5'd30;
         MON_FEB: len = leap ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] d;
      case (month)
         MON_JAN: d = 9'd0;
         MON_FEB: d = 9'd31;
         MON_MAR: d = 9'd59;
         MON_APR: d = 9'd90;
         MON_MAY: d = 9'd120;
         MON_JUN: d = 9'd151;
         MON_JUL: d = 9'd181;
         MON_AUG: d = 9'd212;
         MON_SEP: d = 9'd243;
         MON_OCT: d = 9'd273;
         MON_NOV: d = 9'd304;
         MON_DEC: d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/cde_check.sv
// ----------------------------------------------------------------------------
// cde_check
// First pipeline stage: year mapping, leap flag and field range checks.
// ----------------------------------------------------------------------------
module cde_check import cde_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        year_two_digits,
   input  logic        in_valid,
   output logic        in_ready,
   input  cde_req_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output cde_chk_type out_data
);

   logic        valid_ff;
   cde_chk_type data_ff;
   cde_chk_type data_in;
   logic        bad_year;
   logic        bad_month;
   logic        bad_day;
   logic        bad_time;
   logic [6:0]  years;
   logic        leap;

   always_comb begin
      if (year_two_digits) begin
         bad_year = (in_data.year > TWO_DIGIT_LAST) ||
                    ((in_data.year >= YEAR_PIVOT) && (in_data.year < TWO_DIGIT_FIRST));
         years    = (in_data.year < YEAR_PIVOT) ? 7'(in_data.year + CENTURY_OFFSET)
                                                : 7'(in_data.year - TWO_DIGIT_FIRST);
      end else begin
         bad_year = (in_data.year < FULL_YEAR_FIRST) || (in_data.year > FULL_YEAR_LAST);
         years    = 7'(in_data.year - FULL_YEAR_FIRST);
      end
      // only century in range is 2000, which is a leap year
      leap      = (years[1:0] == LEAP_PHASE);
      bad_month = (in_data.month < MON_JAN) || (in_data.month > MON_DEC);
      bad_day   = (in_data.day == 5'd0) ||
                  (in_data.day > month_length(in_data.month, leap));
      bad_time  = (in_data.hour > MAX_HOUR) || (in_data.minute > MAX_MINUTE) ||
                  (in_data.second > MAX_MINUTE);

      data_in.years  = years;
      data_in.month  = in_data.month;
      data_in.day    = in_data.day;
      data_in.hour   = in_data.hour;
      data_in.minute = in_data.minute;
      data_in.second = in_data.second;
      data_in.leap   = leap;
      data_in.bad    = bad_year || bad_month || bad_day || bad_time;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/cde_days.sv
// ----------------------------------------------------------------------------
// cde_days
// Second pipeline stage: closed-form day count and month count.
// ----------------------------------------------------------------------------
module cde_days import cde_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  cde_chk_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output cde_day_type out_data
);

   logic        valid_ff;
   cde_day_type data_ff;
   cde_day_type data_in;
   logic [15:0] days_sum;
   logic        leap_day;

   always_comb begin
      // feb 29 already passed this year
      leap_day = in_data.leap && (in_data.month > MON_FEB);
      // leap years in 1970 .. year-1 is (years + 1) / 4
      days_sum = 16'(in_data.years) * 16'(DAYS_PER_YEAR)
               + ((16'(in_data.years) + 16'd1) >> 2)
               + 16'(days_before_month(in_data.month))
               + 16'(in_data.day) - 16'd1
               + 16'(leap_day);

      data_in.years  = in_data.years;
      data_in.months = 10'(in_data.years) * 10'(MONTHS_PER_YEAR) + 10'(in_data.month);
      data_in.days   = days_sum[14:0];
      data_in.hour   = in_data.hour;
      data_in.minute = in_data.minute;
      data_in.second = in_data.second;
      data_in.bad    = in_data.bad;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/cde_scale.sv
// ----------------------------------------------------------------------------
// cde_scale
// Three pipeline stages: weeks and hours, then minutes, then seconds and
// the final result word with counts cleared on bad input.
// ----------------------------------------------------------------------------
module cde_scale import cde_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  cde_day_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output cde_rsp_type out_data
);

   logic         hrs_valid_ff;
   cde_hrs_type  hrs_ff;
   cde_hrs_type  hrs_in;
   logic         hrs_ready;
   logic         mins_valid_ff;
   cde_mins_type mins_ff;
   cde_mins_type mins_in;
   logic         mins_ready;
   logic         rsp_valid_ff;
   cde_rsp_type  rsp_ff;
   cde_rsp_type  rsp_in;
   logic [31:0]  week_prod;
   logic [31:0]  seconds;

   // stage: weeks by reciprocal multiply, hours
   always_comb begin
      week_prod = (32'(in_data.days) + 32'(WEEK_OFFSET)) * 32'(WEEK_RECIP);

      hrs_in.years  = in_data.years;
      hrs_in.months = in_data.months;
      hrs_in.days   = in_data.days;
      hrs_in.weeks  = 12'(week_prod >> WEEK_SHIFT);
      hrs_in.hours  = 20'(in_data.days) * 20'(HOURS_PER_DAY) + 20'(in_data.hour);
      hrs_in.minute = in_data.minute;
      hrs_in.second = in_data.second;
      hrs_in.bad    = in_data.bad;
   end

   // stage: minutes
   always_comb begin
      mins_in.years   = hrs_ff.years;
      mins_in.months  = hrs_ff.months;
      mins_in.days    = hrs_ff.days;
      mins_in.weeks   = hrs_ff.weeks;
      mins_in.hours   = hrs_ff.hours;
      mins_in.minutes = 26'(hrs_ff.hours) * 26'(MINUTES_PER_HOUR) + 26'(hrs_ff.minute);
      mins_in.second  = hrs_ff.second;
      mins_in.bad     = hrs_ff.bad;
   end

   // stage: seconds, counts cleared on bad input
   always_comb begin
      seconds = 32'(mins_ff.minutes) * 32'(SECONDS_PER_MINUTE) + 32'(mins_ff.second);
      if (mins_ff.bad) begin
         rsp_in = '0;
      end else begin
         rsp_in.epoch_years   = mins_ff.years;
         rsp_in.epoch_months  = mins_ff.months;
         rsp_in.epoch_days    = mins_ff.days;
         rsp_in.epoch_weeks   = mins_ff.weeks;
         rsp_in.epoch_hours   = mins_ff.hours;
         rsp_in.epoch_minutes = mins_ff.minutes;
         rsp_in.epoch_seconds = seconds;
      end
      rsp_in.bad_input = mins_ff.bad;
   end

   assign mins_ready = !rsp_valid_ff || out_ready;
   assign hrs_ready  = !mins_valid_ff || mins_ready;
   assign in_ready   = !hrs_valid_ff || hrs_ready;
   assign out_valid  = rsp_valid_ff;
   assign out_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hrs_valid_ff  <= 1'b0;
         mins_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            hrs_valid_ff <= in_valid;
         end
         if (hrs_ready) begin
            mins_valid_ff <= hrs_valid_ff;
         end
         if (mins_ready) begin
            rsp_valid_ff <= mins_valid_ff;
         end
      end
      if (in_ready && in_valid) begin
         hrs_ff <= hrs_in;
      end
      if (hrs_ready && hrs_valid_ff) begin
         mins_ff <= mins_in;
      end
      if (mins_ready && mins_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: rtl/civil_date_to_epoch_counts.sv
// ----------------------------------------------------------------------------
// civil_date_to_epoch_counts
// Converts a calendar date and time to counts since 1970-01-01 00:00:00.
//
// Usage:
//   req_ channel carries one date/time word (year, month, day, hour, minute,
//   second); rsp_ channel returns one result word per request with years,
//   months, days, weeks (offset by three days), hours, minutes and seconds
//   since the epoch, plus bad_input. With bad_input set all counts are zero.
//   csr_wr_en / csr_wr_data write year_two_digits (1: two-digit year, below
//   40 is 20xx, 70..99 is 19xx, else bad). Write it only while no word is
//   in flight. Each word passes five registered stages: check, day count,
//   hours, minutes, seconds. Throughput is one word per cycle unless
//   rsp_ready stalls; every stage holds its own valid bit and the constant
//   multiplies set the stage depth. A stalled rsp_ready holds the output
//   word and fills the stages behind it; req_ready drops only when all five
//   stages are full. Reset empties the pipeline and clears year_two_digits.
// ----------------------------------------------------------------------------
module civil_date_to_epoch_counts import cde_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  cde_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cde_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic        year_two_digits_ff;
   logic        chk_valid;
   logic        chk_ready;
   cde_chk_type chk_data;
   logic        day_valid;
   logic        day_ready;
   cde_day_type day_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         year_two_digits_ff <= 1'b0;
      end else if (csr_wr_en) begin
         year_two_digits_ff <= csr_wr_data;
      end
   end

   cde_check u_check (
      .clock           (clock),
      .reset           (reset),
      .year_two_digits (year_two_digits_ff),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .in_data         (req_data),
      .out_valid       (chk_valid),
      .out_ready       (chk_ready),
      .out_data        (chk_data)
   );

   cde_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chk_valid),
      .in_ready  (chk_ready),
      .in_data   (chk_data),
      .out_valid (day_valid),
      .out_ready (day_ready),
      .out_data  (day_data)
   );

   cde_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (day_valid),
      .in_ready  (day_ready),
      .in_data   (day_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // pipeline is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   // bad input clears the year, day and second counts
   a_bad_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_input |->
         (rsp_data.epoch_years == 7'd0) && (rsp_data.epoch_days == 15'd0) &&
         (rsp_data.epoch_seconds == 32'd0))
      else $error("counts not cleared on bad input");

   // weeks agree with days
   a_weeks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bad_input |->
         (16'(rsp_data.epoch_weeks) * 16'd7 <= 16'(rsp_data.epoch_days) + 16'd3) &&
         (16'(rsp_data.epoch_days) + 16'd3 < 16'(rsp_data.epoch_weeks) * 16'd7 + 16'd7))
      else $error("week count out of step with day count");

   // hours agree with days
   a_hours: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bad_input |->
         (rsp_data.epoch_hours >= 20'(rsp_data.epoch_days) * 20'd24) &&
         (rsp_data.epoch_hours < 20'(rsp_data.epoch_days) * 20'd24 + 20'd24))
      else $error("hour count out of step with day count");

   // months agree with years
   a_months: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bad_input |->
         (rsp_data.epoch_months > 10'(rsp_data.epoch_years) * 10'd12) &&
         (rsp_data.epoch_months <= 10'(rsp_data.epoch_years) * 10'd12 + 10'd12))
      else $error("month count out of step with year count");

endmodule

// File: tb/tb_civil_date_to_epoch_counts.sv
// ----------------------------------------------------------------------------
// tb_civil_date_to_epoch_counts
// Feeds directed and random calendar times through the date converter in full
// and two-digit year modes, with random idling on both sides and one long
// output hold-off. Every result word is checked field by field against counts
// worked out independently in the scoreboard.
// ----------------------------------------------------------------------------
module tb_civil_date_to_epoch_counts import cde_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   class epoch_scoreboard;
      bit          two_digit;
      int unsigned error_count;
      cde_rsp_type expected_q[$];

      static function bit is_leap(int unsigned y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      static function int unsigned leaps_upto(int unsigned y);
         return y / 4 - y / 100 + y / 400;
      endfunction

      static function int unsigned days_in_month(logic [3:0] mo, bit leap);
         case (mo)
            MON_FEB:                            return leap ? 29 : 28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
            default:                            return 31;
         endcase
      endfunction

      static function int unsigned days_before(logic [3:0] mo);
         case (mo)
            MON_JAN: return 0;
            MON_FEB: return 31;
            MON_MAR: return 59;
            MON_APR: return 90;
            MON_MAY: return 120;
            MON_JUN: return 151;
            MON_JUL: return 181;
            MON_AUG: return 212;
            MON_SEP: return 243;
            MON_OCT: return 273;
            MON_NOV: return 304;
            default: return 334;
         endcase
      endfunction

      function cde_rsp_type predict_counts(cde_req_type d);
         cde_rsp_type r;
         int unsigned yr, ey, days, hours, mins;
         bit          bad, leap;
         r = '0;
         if (two_digit) begin
            bad = (d.year > 99) || (d.year >= 40 && d.year < 70);
            yr  = (d.year < 40) ? 32'(d.year) + 2000 : 32'(d.year) + 1900;
         end else begin
            yr  = 32'(d.year);
            bad = (d.year < 1970) || (d.year > 2039);
         end
         leap = is_leap(yr);
         if (d.month < MON_JAN || d.month > MON_DEC)
            bad = 1'b1;
         else if (d.day == 0 || 32'(d.day) > days_in_month(d.month, leap))
            bad = 1'b1;
         if (d.day == 0 || d.hour > 23 || d.minute > 59 || d.second > 59)
            bad = 1'b1;
         if (bad) begin
            r.bad_input = 1'b1;
            return r;
         end
         ey   = yr - 1970;
         days = 365 * ey + leaps_upto(yr - 1) - leaps_upto(1969)
                + days_before(d.month) + 32'(d.day) - 1;
         if (d.month > MON_FEB && leap)
            days++;
         hours = days * 24 + 32'(d.hour);
         mins  = hours * 60 + 32'(d.minute);
         r.epoch_years   = 7'(ey);
         r.epoch_months  = 10'(12 * ey + 32'(d.month));
         r.epoch_days    = 15'(days);
         r.epoch_weeks   = 12'((days + 3) / 7);
         r.epoch_hours   = 20'(hours);
         r.epoch_minutes = 26'(mins);
         r.epoch_seconds = mins * 60 + 32'(d.second);
         return r;
      endfunction

      function void note_date(cde_req_type d);
         expected_q.push_back(predict_counts(d));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
         end
      endfunction

      function void check_counts(cde_rsp_type got);
         cde_rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result word with no date pending");
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("epoch_years", 32'(want.epoch_years), 32'(got.epoch_years));
         compare_field("epoch_months", 32'(want.epoch_months), 32'(got.epoch_months));
         compare_field("epoch_days", 32'(want.epoch_days), 32'(got.epoch_days));
         compare_field("epoch_weeks", 32'(want.epoch_weeks), 32'(got.epoch_weeks));
         compare_field("epoch_hours", 32'(want.epoch_hours), 32'(got.epoch_hours));
         compare_field("epoch_minutes", 32'(want.epoch_minutes), 32'(got.epoch_minutes));
         compare_field("epoch_seconds", want.epoch_seconds, got.epoch_seconds);
         compare_field("bad_input", 32'(want.bad_input), 32'(got.bad_input));
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   cde_req_type req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   cde_rsp_type rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_asks = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   epoch_scoreboard sb;

   civil_date_to_epoch_counts i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= 60;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_date(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_counts(rsp_data);
      end
   end

   function automatic cde_req_type civil(int unsigned y, int unsigned mo, int unsigned dy,
                                         int unsigned h, int unsigned mi, int unsigned s);
      cde_req_type d;
      d.year   = 14'(y);
      d.month  = 4'(mo);
      d.day    = 5'(dy);
      d.hour   = 5'(h);
      d.minute = 6'(mi);
      d.second = 6'(s);
      return d;
   endfunction

   // mostly well-formed dates, some with one field spoiled, some pure noise
   function automatic cde_req_type random_date(bit two_dig);
      cde_req_type d;
      int unsigned pick, yr, len;
      pick = $urandom_range(99);
      if (two_dig)
         d.year = 14'($urandom_range(1) ? $urandom_range(39) : $urandom_range(99, 70));
      else
         d.year = 14'($urandom_range(2039, 1970));
      d.month = 4'($urandom_range(12, 1));
      yr  = two_dig ? ((d.year < 40) ? 32'(d.year) + 2000 : 32'(d.year) + 1900)
                    : 32'(d.year);
      len = epoch_scoreboard::days_in_month(d.month, epoch_scoreboard::is_leap(yr));
      d.day    = 5'($urandom_range(len, 1));
      d.hour   = 5'($urandom_range(23));
      d.minute = 6'($urandom_range(59));
      d.second = 6'($urandom_range(59));
      if (pick < 15) begin
         case ($urandom_range(5))
            0: d.year   = 14'($urandom());
            1: d.month  = 4'($urandom());
            2: d.day    = 5'($urandom());
            3: d.hour   = 5'($urandom());
            4: d.minute = 6'($urandom());
            default: d.second = 6'($urandom());
         endcase
      end else if (pick < 30) begin
         d.year   = 14'($urandom());
         d.month  = 4'($urandom());
         d.day    = 5'($urandom());
         d.hour   = 5'($urandom());
         d.minute = 6'($urandom());
         d.second = 6'($urandom());
      end
      return d;
   endfunction

   task automatic send_date(input cde_req_type d);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending, wait for every pending word, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_year_mode(input bit two_dig);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= two_dig;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.two_digit = two_dig;
      @(posedge clock);
   endtask

   initial begin
      bit mode;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_year_mode(1'b0);
      send_date(civil(1970, 1, 1, 0, 0, 0));
      send_date(civil(2039, 12, 31, 23, 59, 59));
      send_date(civil(2038, 1, 19, 3, 14, 7));
      send_date(civil(1969, 12, 31, 23, 59, 59));
      send_date(civil(2040, 1, 1, 0, 0, 0));
      send_date(civil(0, 15, 0, 31, 63, 63));
      send_date(civil(16383, 6, 15, 12, 30, 30));
      // century leap year and the day after
      send_date(civil(2000, 2, 29, 12, 0, 0));
      send_date(civil(2000, 3, 1, 0, 0, 0));
      send_date(civil(2023, 2, 29, 0, 0, 0));
      send_date(civil(2024, 2, 30, 0, 0, 0));
      send_date(civil(1972, 12, 31, 23, 59, 59));
      send_date(civil(1999, 13, 1, 0, 0, 0));
      send_date(civil(1999, 4, 31, 0, 0, 0));
      send_date(civil(1999, 4, 0, 0, 0, 0));
      send_date(civil(2010, 7, 4, 24, 0, 0));
      send_date(civil(2010, 7, 4, 0, 60, 0));
      send_date(civil(2010, 7, 4, 0, 0, 60));
      drain();

      write_year_mode(1'b1);
      send_date(civil(0, 2, 29, 0, 0, 0));
      send_date(civil(39, 12, 31, 23, 59, 59));
      send_date(civil(40, 1, 1, 0, 0, 0));
      send_date(civil(69, 12, 31, 23, 59, 59));
      send_date(civil(70, 1, 1, 0, 0, 0));
      send_date(civil(99, 12, 31, 23, 59, 59));
      send_date(civil(100, 1, 1, 0, 0, 0));
      drain();

      for (int p = 0; p < 8; p++) begin
         mode = p[0];
         write_year_mode(mode);
         case (p / 2)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
         endcase
         repeat (175) send_date(random_date(mode));
         if (p == 1) begin
            // long output hold-off while words keep coming, fills the pipeline
            hold_asks <= hold_asks + 1;
            repeat (30) send_date(random_date(mode));
         end
         drain();
      end

      if (sb.error_count == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
